>>> src/deadline_ordered_alarm_timer_top_defines.svh
// Assertion macros used by the alarm timer top module.
`ifndef DEADLINE_ORDERED_ALARM_TIMER_TOP_DEFINES_SVH
`define DEADLINE_ORDERED_ALARM_TIMER_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DOAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define DOAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/doat_pkg.sv
`timescale 1ns / 1ps
package doat_pkg;

  localparam logic [1:0] ActCheck  = 2'd0;
  localparam logic [1:0] ActAttach = 2'd1;
  localparam logic [1:0] ActCancel = 2'd2;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatPeriod = 2'd1;
  localparam logic [1:0] StatArmed  = 2'd2;

  localparam logic [31:0] MinPeriodic = 32'd25;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] time_now;
    logic [3:0]  slot;
    logic [31:0] period;
    logic        periodic_mode;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [3:0]  fired_slot;
    logic        pending;
    logic [31:0] earliest_due;
  } rsp_t;

endpackage

>>> src/deadline_ordered_alarm_timer_top.sv
`timescale 1ns / 1ps
// Channel  | Ports                     | Handshake
// request  | start_i, req_i, busy_o    | taken when start_i && !busy_o
// response | rsp_valid_o, rsp_o        | one-cycle strobe, cannot be held off
// The response strobe follows StHead and StResp directly for a check that fires nothing or
// a rejected attach; a cancel first scans and shifts the order list, an attach waits for
// the divider's remainder and then scans and inserts, and a fired periodic check does both,
// with the scans of the order list moving one entry per cycle.
// Reset clears armed flags and the count; slot stores are undefined until written.
// busy_o stays high from acceptance until the response strobe; the receiver cannot stall.
module deadline_ordered_alarm_timer_top #(
  parameter int NUM_SLOTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  doat_pkg::req_t req_i,
  output logic           busy_o,
  output logic           rsp_valid_o,
  output doat_pkg::rsp_t rsp_o
);
  import doat_pkg::*;
  `include "deadline_ordered_alarm_timer_top_defines.svh"

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StRem   = 8'b00000010,
    StShift = 8'b00000100,
    StDiv   = 8'b00001000,
    StFind  = 8'b00010000,
    StIns   = 8'b00100000,
    StHead  = 8'b01000000,
    StResp  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [31:0] dl_mem [NUM_SLOTS];
  logic [31:0] per_mem [NUM_SLOTS];
  logic [31:0] cre_mem [NUM_SLOTS];
  logic        rep_q [NUM_SLOTS];
  logic [IW-1:0] ord_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] armed_q;
  logic [CW-1:0] cnt_q;

  req_t        req_q;
  logic [IW-1:0] tgt_q;
  logic [CW-1:0] pos_q;
  logic [31:0] newdl_q;
  logic [1:0]  stat_q;
  logic        fired_q;
  logic        ins_q;
  rsp_t        rsp_q;
  logic        rv_q;

  logic        div_start, div_done;
  logic [31:0] div_rem;
  logic [IW-1:0] head;
  logic [IW-1:0] cur;
  logic [32:0] sum;
  logic [31:0] step_amt;
  logic        in_range;

  assign head = ord_q[0];
  assign cur  = ord_q[pos_q[IW-1:0]];
  assign in_range = ({28'd0, req_i.slot} < 32'(NUM_SLOTS));

  doat_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(req_q.time_now - cre_mem[tgt_q]),
    .divisor_i(per_mem[tgt_q]),
    .done_o(div_done), .rem_o(div_rem)
  );

  // Phase term and saturating deadline add.
  assign step_amt = per_mem[tgt_q] - ((rep_q[tgt_q] && per_mem[tgt_q] != '0) ? div_rem : '0);
  assign sum = {1'b0, req_q.time_now} + {1'b0, step_amt};

  assign div_start = (state_q == StDiv) && !ins_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      armed_q <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      ins_q   <= 1'b0;
    end else begin
      rv_q <= (state_q == StResp);
      unique case (state_q)
        StIdle: begin
          if (start_i && !rv_q) begin
            req_q <= req_i;
            pos_q <= '0;
            if (req_i.action == ActCheck) begin
              stat_q <= StatOk;
              if (cnt_q != '0 && dl_mem[ord_q[0]] <= req_i.time_now) begin
                tgt_q   <= ord_q[0];
                fired_q <= 1'b1;
                armed_q[ord_q[0]] <= 1'b0;
                state_q <= StRem;
              end else begin
                tgt_q   <= req_i.slot[IW-1:0];
                fired_q <= 1'b0;
                state_q <= StHead;
              end
            end else begin
              tgt_q   <= req_i.slot[IW-1:0];
              fired_q <= 1'b0;
              if (req_i.action == ActAttach && in_range) begin
                if (armed_q[req_i.slot[IW-1:0]]) begin
                  stat_q  <= StatArmed;
                  state_q <= StHead;
                end else if (req_i.periodic_mode && req_i.period < MinPeriodic) begin
                  stat_q  <= StatPeriod;
                  state_q <= StHead;
                end else begin
                  stat_q <= StatOk;
                  cre_mem[req_i.slot[IW-1:0]] <= req_i.time_now;
                  per_mem[req_i.slot[IW-1:0]] <= req_i.period;
                  rep_q[req_i.slot[IW-1:0]]   <= req_i.periodic_mode;
                  ins_q   <= 1'b0;
                  state_q <= StDiv;
                end
              end else if (req_i.action == ActCancel && in_range
                           && armed_q[req_i.slot[IW-1:0]]) begin
                stat_q <= StatOk;
                armed_q[req_i.slot[IW-1:0]] <= 1'b0;
                state_q <= StRem;
              end else begin
                stat_q  <= StatOk;
                state_q <= StHead;
              end
            end
          end
        end
        // Scan for the slot to remove.
        StRem: begin
          if (cur == tgt_q) state_q <= StShift;
          else pos_q <= pos_q + 1'b1;
        end
        // Close the gap, one entry per cycle.
        StShift: begin
          if (32'(pos_q) + 1 < 32'(cnt_q)) begin
            ord_q[pos_q[IW-1:0]] <= ord_q[IW'(pos_q + 1'b1)];
            pos_q <= pos_q + 1'b1;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            pos_q <= '0;
            if (fired_q && rep_q[tgt_q]) state_q <= StDiv;
            else state_q <= StHead;
          end
        end
        // Wait for the remainder, then form the deadline.
        StDiv: begin
          if (!ins_q) ins_q <= 1'b1;
          else if (div_done) begin
            ins_q   <= 1'b0;
            newdl_q <= sum[32] ? '1 : sum[31:0];
            dl_mem[tgt_q] <= sum[32] ? '1 : sum[31:0];
            armed_q[tgt_q] <= 1'b1;
            pos_q   <= '0;
            state_q <= StFind;
          end
        end
        // Find the first later deadline.
        StFind: begin
          if (pos_q == cnt_q || newdl_q < dl_mem[cur]) begin
            pos_q   <= cnt_q;
            tgt_q   <= tgt_q;
            req_q.period <= 32'(pos_q);
            state_q <= StIns;
          end else pos_q <= pos_q + 1'b1;
        end
        // Shift the tail up and drop the slot in.
        StIns: begin
          if (32'(pos_q) > req_q.period) begin
            ord_q[pos_q[IW-1:0]] <= ord_q[IW'(pos_q - 1'b1)];
            pos_q <= pos_q - 1'b1;
          end else begin
            ord_q[pos_q[IW-1:0]] <= tgt_q;
            cnt_q   <= cnt_q + 1'b1;
            state_q <= StHead;
          end
        end
        StHead: begin
          rsp_q.status       <= stat_q;
          rsp_q.fired        <= fired_q;
          rsp_q.fired_slot   <= fired_q ? 4'(tgt_q) : 4'd0;
          rsp_q.pending      <= (cnt_q != '0);
          rsp_q.earliest_due <= (cnt_q != '0) ? dl_mem[head] : '0;
          state_q <= StResp;
        end
        StResp: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy_o      = (state_q != StIdle) || rv_q;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  `DOAT_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, 32'(cnt_q) <= NUM_SLOTS, "count overflow")
  `DOAT_ASSERT_IMP(a_cnt_armed, clk_i, rst_ni, state_q == StIdle, 32'(cnt_q) == 32'($countones(armed_q)), "count mismatch")
  `DOAT_ASSERT_NEXT(a_resp, clk_i, rst_ni, state_q == StResp, rsp_valid_o, "missing response")
  `DOAT_ASSERT_IMP(a_busy, clk_i, rst_ni, rsp_valid_o, busy_o, "not busy at response")
endmodule

>>> src/doat_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; only the remainder is kept.
module doat_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] rem_o
);
  import doat_pkg::*;

  logic [31:0] rem_q, rem_d, num_q, num_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d, done_q, done_d;
  logic [32:0] trial;

  // One shift and subtract step.
  always_comb begin
    trial  = {rem_q, num_q[31]} - {1'b0, den_q};
    rem_d  = rem_q;
    num_d  = num_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      num_d = dividend_i;
      cnt_d = 6'd32;
      run_d = 1'b1;
    end else if (run_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (trial[32]) begin
        rem_d = {rem_q[30:0], num_q[31]};
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    if (start_i) den_q <= divisor_i;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import doat_pkg::*;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic rsp_valid_o;
  rsp_t rsp_o;

  deadline_ordered_alarm_timer_top #(.NUM_SLOTS(SLOTS)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .rsp_valid_o(rsp_valid_o), .rsp_o(rsp_o)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow copy of the alarm state.
  logic [31:0] alarm_deadline [SLOTS];
  logic [31:0] alarm_period [SLOTS];
  logic [31:0] alarm_created [SLOTS];
  logic        alarm_repeats [SLOTS];
  logic        alarm_armed [SLOTS];
  logic [3:0]  deadline_order [SLOTS];
  int          armed_total;

  req_t pending_reqs[$];
  rsp_t awaited_rsps[$];
  int   errors;
  int   cycles;
  bit   accepted;
  logic [31:0] clock_ms;

  function automatic logic [31:0] saturating_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void unlink_alarm(logic [3:0] s);
    int k;
    int pos;
    pos = -1;
    for (k = 0; k < armed_total; k++)
      if (pos < 0 && deadline_order[k] == s) pos = k;
    if (pos >= 0) begin
      for (k = pos; k + 1 < armed_total; k++) deadline_order[k] = deadline_order[k + 1];
      armed_total--;
    end
  endfunction

  // Arms a slot; the new entry goes behind every equal deadline.
  function automatic void arm_alarm(logic [3:0] s, logic [31:0] now);
    logic [31:0] phase;
    int pos;
    int k;
    phase = 32'd0;
    if (alarm_repeats[s] && alarm_period[s] != 32'd0)
      phase = (now - alarm_created[s]) % alarm_period[s];
    alarm_deadline[s] = saturating_sum(now, alarm_period[s] - phase);
    alarm_armed[s] = 1'b1;
    if (armed_total < SLOTS) begin
      pos = armed_total;
      for (k = armed_total - 1; k >= 0; k--)
        if (alarm_deadline[s] < alarm_deadline[deadline_order[k]]) pos = k;
      for (k = armed_total; k > pos; k--) deadline_order[k] = deadline_order[k - 1];
      deadline_order[pos] = s;
      armed_total++;
    end
  endfunction

  function automatic rsp_t predict_alarm_step(req_t r);
    rsp_t o;
    logic [3:0] h;
    o = '0;
    case (r.action)
      ActCheck: begin
        if (armed_total > 0) begin
          h = deadline_order[0];
          if (alarm_deadline[h] <= r.time_now) begin
            unlink_alarm(h);
            alarm_armed[h] = 1'b0;
            if (alarm_repeats[h]) arm_alarm(h, r.time_now);
            o.fired = 1'b1;
            o.fired_slot = h;
          end
        end
      end
      ActAttach: begin
        if (alarm_armed[r.slot]) begin
          o.status = StatArmed;
        end else if (r.periodic_mode && r.period < MinPeriodic) begin
          o.status = StatPeriod;
        end else begin
          alarm_created[r.slot] = r.time_now;
          alarm_period[r.slot] = r.period;
          alarm_repeats[r.slot] = r.periodic_mode;
          arm_alarm(r.slot, r.time_now);
        end
      end
      ActCancel: begin
        if (alarm_armed[r.slot]) begin
          unlink_alarm(r.slot);
          alarm_armed[r.slot] = 1'b0;
        end
      end
      default: ;
    endcase
    o.pending = armed_total > 0;
    o.earliest_due = armed_total > 0 ? alarm_deadline[deadline_order[0]] : 32'd0;
    return o;
  endfunction

  function automatic req_t make_req(logic [1:0] act, logic [31:0] now, logic [3:0] s,
                                    logic [31:0] per, logic mode);
    req_t r;
    r.action = act;
    r.time_now = now;
    r.slot = s;
    r.period = per;
    r.periodic_mode = mode;
    return r;
  endfunction

  // Driver: presents queued transactions after a random gap.
  int gap_left;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
      gap_left <= 0;
    end else if (start_i && accepted) begin
      start_i <= 1'b0;
      gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
    end else if (!start_i && pending_reqs.size() > 0) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else begin
        req_i <= pending_reqs[0];
        start_i <= 1'b1;
      end
    end
  end

  // Acceptance is sampled at the rising edge; the prediction is made then.
  always @(posedge clk_i) begin
    accepted <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o) begin
      awaited_rsps.push_back(predict_alarm_step(req_i));
      void'(pending_reqs.pop_front());
    end
  end

  // Monitor: compares every response strobe with the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (awaited_rsps.size() == 0) begin
        $error("response with no transaction outstanding");
        errors++;
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.fired !== want.fired) begin
          $error("fired: expected %0d actual %0d", want.fired, rsp_o.fired);
          errors++;
        end
        if (rsp_o.fired_slot !== want.fired_slot) begin
          $error("fired_slot: expected %0d actual %0d", want.fired_slot, rsp_o.fired_slot);
          errors++;
        end
        if (rsp_o.pending !== want.pending) begin
          $error("pending: expected %0d actual %0d", want.pending, rsp_o.pending);
          errors++;
        end
        if (rsp_o.earliest_due !== want.earliest_due) begin
          $error("earliest_due: expected %h actual %h", want.earliest_due,
                 rsp_o.earliest_due);
          errors++;
        end
      end
    end
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("deadline_ordered_alarm_timer_top verification failed");
      $finish;
    end
  end

  // Random traffic: mostly attach, check and cancel around a rising clock,
  // with occasional jumps to a random point of the time range.
  function automatic req_t random_req();
    logic [31:0] per;
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 60);
    case ($urandom_range(0, 5))
      0: per = $urandom_range(0, 30);
      1: per = $urandom();
      2: per = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: per = $urandom_range(20, 200);
    endcase
    if (pick < 40) return make_req(ActCheck, clock_ms, 4'($urandom()), $urandom(), 1'($urandom()));
    if (pick < 80) return make_req(ActAttach, clock_ms, 4'($urandom()), per, 1'($urandom()));
    if (pick < 97) return make_req(ActCancel, clock_ms, 4'($urandom()), $urandom(), 1'($urandom()));
    return make_req(2'd3, clock_ms, 4'($urandom()), $urandom(), 1'($urandom()));
  endfunction

  initial begin
    int k;
    errors = 0;
    cycles = 0;
    armed_total = 0;
    for (k = 0; k < SLOTS; k++) alarm_armed[k] = 1'b0;
    rst_ni = 1'b0;

    // Directed opening: extremes, each rejection, ties, wrap and saturation.
    pending_reqs.push_back(make_req(ActCheck, 32'd0, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'd100, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd100, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'd100, 4'd1, 32'd24, 1'b1));
    pending_reqs.push_back(make_req(ActAttach, 32'd100, 4'd1, 32'd25, 1'b1));
    pending_reqs.push_back(make_req(ActAttach, 32'd100, 4'd1, 32'd50, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'd100, 4'd2, 32'd25, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'd110, 4'd15, 32'd15, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd124, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd125, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd137, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd137, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCancel, 32'd140, 4'd9, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCancel, 32'd140, 4'd1, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'hFFFF_FFF0, 4'd3, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(2'd3, 32'hFFFF_FFFF, 4'd3, 32'hFFFF_FFFF, 1'b1));
    pending_reqs.push_back(make_req(ActCheck, 32'hFFFF_FFFF, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActAttach, 32'hFFFF_FF00, 4'd4, 32'd1000, 1'b1));
    pending_reqs.push_back(make_req(ActCheck, 32'd500, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'hFFFF_FFFF, 4'd0, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCancel, 32'd0, 4'd3, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCancel, 32'd0, 4'd4, 32'd0, 1'b0));
    pending_reqs.push_back(make_req(ActCheck, 32'd0, 4'd0, 32'd0, 1'b0));
    clock_ms = 32'd1000;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Random part, fed in small batches so the queue stays short.
    for (k = 0; k < 1400; k++) begin
      while (pending_reqs.size() > 8) @(posedge clk_i);
      pending_reqs.push_back(random_req());
    end
    while (pending_reqs.size() > 0) @(posedge clk_i);
    while (awaited_rsps.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("deadline_ordered_alarm_timer_top verification clean");
    end else begin
      $display("deadline_ordered_alarm_timer_top verification failed");
    end
    $finish;
  end

endmodule
